// ----- rtl/avws_pkg.sv -----
package avws_pkg;

  localparam int AXIS_SIZE      = 64;
  localparam int AXIS_BITS      = $clog2(AXIS_SIZE);
  localparam int VOXEL_BITS     = 16;
  localparam int NUM_BANKS      = 8;
  localparam int BANK_AXIS_BITS = AXIS_BITS - 1;
  localparam int BANK_ADDR_BITS = 3 * BANK_AXIS_BITS;
  localparam int BANK_DEPTH     = 1 << BANK_ADDR_BITS;

  localparam int CFG_DATA_BITS = 60;
  localparam int CFG_IDX_BITS  = 3;
  localparam int FIELD_BITS    = 20;
  localparam int OFF_BITS      = 21;
  localparam int PROD_BITS     = FIELD_BITS + OFF_BITS;
  localparam int ACC_BITS      = 44;
  localparam int DIM_BITS      = 7;
  localparam int DIMS_BITS     = 3 * DIM_BITS;
  localparam int FRAC_BITS     = 16;
  localparam int POS_BITS      = AXIS_BITS + 1;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_Z  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_Y  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_X  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRANS  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PIVOT  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIMS   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORDER  = 3'd6;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [CFG_DATA_BITS-1:0] ROW_Z_RESET = 60'd65536;
  localparam logic [CFG_DATA_BITS-1:0] ROW_Y_RESET = 60'd68719476736;
  localparam logic [CFG_DATA_BITS-1:0] ROW_X_RESET = 60'd72057594037927936;
  localparam logic [DIMS_BITS-1:0]     DIMS_RESET  = 21'd1056832;

  typedef struct packed {
    logic [2:0][CFG_DATA_BITS-1:0] rows;
    logic [CFG_DATA_BITS-1:0]      trans;
    logic [CFG_DATA_BITS-1:0]      pivot;
    logic [DIMS_BITS-1:0]          dims;
    logic                          order;
  } cfg_t;

  typedef struct packed {
    logic                                        valid;
    logic                                        is_write;
    logic [2:0]                                  wr_bank;
    logic [BANK_ADDR_BITS-1:0]                   wr_addr;
    logic [VOXEL_BITS-1:0]                       wr_data;
    logic [NUM_BANKS-1:0][BANK_ADDR_BITS-1:0]    rd_addr;
    logic [2:0]                                  base_par;
    logic [2:0][FRAC_BITS-1:0]                   frac;
    logic                                        in_vol;
  } mem_req_t;

  typedef struct packed {
    logic                                     valid;
    logic                                     in_vol;
    logic [2:0]                               base_par;
    logic [2:0][FRAC_BITS-1:0]                frac;
    logic [NUM_BANKS-1:0][VOXEL_BITS-1:0]     corner;
  } rd_rsp_t;

  function automatic logic signed [FIELD_BITS-1:0] fld(input logic [CFG_DATA_BITS-1:0] p,
                                                      input int slot);
    return $signed(p[slot*FIELD_BITS +: FIELD_BITS]);
  endfunction

  // Linear blend with 16-bit weight; a zero weight passes a through untouched.
  function automatic logic [VOXEL_BITS-1:0] lerp(input logic [VOXEL_BITS-1:0] a,
                                                 input logic [VOXEL_BITS-1:0] b,
                                                 input logic [FRAC_BITS-1:0] f);
    logic [VOXEL_BITS+FRAC_BITS:0] acc;
    acc = (VOXEL_BITS+FRAC_BITS+1)'(a) * (VOXEL_BITS+FRAC_BITS+1)'(17'h1_0000 - 17'(f))
        + (VOXEL_BITS+FRAC_BITS+1)'(b) * (VOXEL_BITS+FRAC_BITS+1)'(f)
        + (VOXEL_BITS+FRAC_BITS+1)'(17'h0_8000);
    if (f == '0) begin
      return a;
    end
    return acc[FRAC_BITS +: VOXEL_BITS];
  endfunction

endpackage

// ----- rtl/avws_if.sv -----
interface avws_req_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [avws_pkg::AXIS_BITS-1:0] coord_z;
  logic [avws_pkg::AXIS_BITS-1:0] coord_y;
  logic [avws_pkg::AXIS_BITS-1:0] coord_x;
  logic [avws_pkg::VOXEL_BITS-1:0] voxel_value;
  modport source(output valid, opcode, coord_z, coord_y, coord_x, voxel_value, input ready);
  modport sink(input valid, opcode, coord_z, coord_y, coord_x, voxel_value, output ready);
endinterface

interface avws_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [avws_pkg::VOXEL_BITS-1:0] warped_value;
  logic                            in_bounds;
  modport source(output valid, warped_value, in_bounds, input ready);
  modport sink(input valid, warped_value, in_bounds, output ready);
endinterface

interface avws_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [avws_pkg::CFG_IDX_BITS-1:0]  index;
  logic [avws_pkg::CFG_DATA_BITS-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/avws_cfg_regs.sv -----
module avws_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [avws_pkg::CFG_IDX_BITS-1:0]  wr_index,
  input  logic [avws_pkg::CFG_DATA_BITS-1:0] wr_data,
  output avws_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows[0] <= avws_pkg::ROW_Z_RESET;
      cfg.rows[1] <= avws_pkg::ROW_Y_RESET;
      cfg.rows[2] <= avws_pkg::ROW_X_RESET;
      cfg.trans   <= '0;
      cfg.pivot   <= '0;
      cfg.dims    <= avws_pkg::DIMS_RESET;
      cfg.order   <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        avws_pkg::CFG_ROW_Z: cfg.rows[0] <= wr_data;
        avws_pkg::CFG_ROW_Y: cfg.rows[1] <= wr_data;
        avws_pkg::CFG_ROW_X: cfg.rows[2] <= wr_data;
        avws_pkg::CFG_TRANS: cfg.trans   <= wr_data;
        avws_pkg::CFG_PIVOT: cfg.pivot   <= wr_data;
        avws_pkg::CFG_DIMS:  cfg.dims    <= wr_data[avws_pkg::DIMS_BITS-1:0];
        avws_pkg::CFG_ORDER: cfg.order   <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/avws_xform.sv -----
module avws_xform (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic                            in_valid,
  input  logic                            opcode,
  input  logic [avws_pkg::AXIS_BITS-1:0]  coord_z,
  input  logic [avws_pkg::AXIS_BITS-1:0]  coord_y,
  input  logic [avws_pkg::AXIS_BITS-1:0]  coord_x,
  input  logic [avws_pkg::VOXEL_BITS-1:0] voxel_value,
  input  avws_pkg::cfg_t                  cfg,
  output avws_pkg::mem_req_t              mem_req
);

  localparam int AB  = avws_pkg::AXIS_BITS;
  localparam int PB  = avws_pkg::POS_BITS;
  localparam int BAB = avws_pkg::BANK_AXIS_BITS;

  logic [2:0][AB-1:0] in_crd;
  assign in_crd = {coord_x, coord_y, coord_z};

  // Stage A: offsets from the pivot.
  logic                                   a_valid;
  logic                                   a_op;
  logic [2:0][AB-1:0]                     a_crd;
  logic [avws_pkg::VOXEL_BITS-1:0]        a_val;
  logic signed [avws_pkg::OFF_BITS-1:0]   a_off [3];
  logic signed [avws_pkg::OFF_BITS-1:0]   a_off_next [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      a_off_next[c] = $signed({{(avws_pkg::OFF_BITS-AB-8){1'b0}}, in_crd[c], 8'b0})
                    - avws_pkg::fld(cfg.pivot, c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
    if (adv) begin
      a_op  <= opcode;
      a_crd <= in_crd;
      a_val <= voxel_value;
      for (int c = 0; c < 3; c++) begin
        a_off[c] <= a_off_next[c];
      end
    end
  end

  // Stage B: nine coefficient products, translation plus pivot.
  logic                                   b_valid;
  logic                                   b_op;
  logic [2:0][AB-1:0]                     b_crd;
  logic [avws_pkg::VOXEL_BITS-1:0]        b_val;
  logic signed [avws_pkg::PROD_BITS-1:0]  b_prod [3][3];
  logic signed [avws_pkg::OFF_BITS-1:0]   b_tadd [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
    if (adv) begin
      b_op  <= a_op;
      b_crd <= a_crd;
      b_val <= a_val;
      for (int r = 0; r < 3; r++) begin
        b_tadd[r] <= avws_pkg::fld(cfg.trans, r) + avws_pkg::fld(cfg.pivot, r);
        for (int c = 0; c < 3; c++) begin
          b_prod[r][c] <= avws_pkg::fld(cfg.rows[r], c) * a_off[c];
        end
      end
    end
  end

  // Stage C: mapped source position in signed Q.24.
  logic                                  c_valid;
  logic                                  c_op;
  logic [2:0][AB-1:0]                    c_crd;
  logic [avws_pkg::VOXEL_BITS-1:0]       c_val;
  logic signed [avws_pkg::ACC_BITS-1:0]  c_s [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
    if (adv) begin
      c_op  <= b_op;
      c_crd <= b_crd;
      c_val <= b_val;
      for (int r = 0; r < 3; r++) begin
        c_s[r] <= b_prod[r][0] + b_prod[r][1] + b_prod[r][2]
                + $signed({b_tadd[r], 16'b0});
      end
    end
  end

  // Stage D: bounds test, base corner, fractions and bank addresses.
  avws_pkg::mem_req_t                    d_next;
  logic [PB-1:0]                         dim [3];
  logic signed [PB:0]                    dim_m [3];
  logic signed [avws_pkg::ACC_BITS-1:0]  lo_lim [3];
  logic signed [avws_pkg::ACC_BITS-1:0]  hi_lim [3];
  logic signed [avws_pkg::ACC_BITS-1:0]  rnd [3];
  logic [PB-1:0]                         nq [3];
  logic [PB-1:0]                         base [3];
  logic [PB-1:0]                         cpos;
  logic                                  par;
  logic                                  in_vol;

  always_comb begin
    in_vol = 1'b1;
    for (int r = 0; r < 3; r++) begin
      dim[r] = cfg.dims[r*avws_pkg::DIM_BITS +: avws_pkg::DIM_BITS];
      if (dim[r] > PB'(avws_pkg::AXIS_SIZE)) begin
        dim[r] = PB'(avws_pkg::AXIS_SIZE);
      end
      dim_m[r]  = $signed({1'b0, dim[r]}) - $signed({{PB{1'b0}}, cfg.order});
      lo_lim[r] = $signed({{(avws_pkg::ACC_BITS-25){1'b0}}, cfg.order, 24'b0});
      hi_lim[r] = $signed({{(avws_pkg::ACC_BITS-PB-25){dim_m[r][PB]}}, dim_m[r], 24'b0});
      if (c_s[r] < lo_lim[r] || c_s[r] >= hi_lim[r]) begin
        in_vol = 1'b0;
      end
      rnd[r] = c_s[r] + $signed(avws_pkg::ACC_BITS'(24'h80_0000));
      nq[r]  = rnd[r][24 +: PB];
      if (nq[r] > dim[r] - PB'(1)) begin
        nq[r] = dim[r] - PB'(1);
      end
      if (cfg.order) begin
        base[r] = {1'b0, c_s[r][24 +: AB]};
      end else begin
        base[r] = nq[r];
      end
    end
    d_next          = '0;
    d_next.valid    = c_valid;
    d_next.is_write = (c_op == avws_pkg::OP_WRITE);
    d_next.wr_bank  = {c_crd[0][0], c_crd[1][0], c_crd[2][0]};
    d_next.wr_addr  = {c_crd[0][AB-1:1], c_crd[1][AB-1:1], c_crd[2][AB-1:1]};
    d_next.wr_data  = c_val;
    d_next.in_vol   = in_vol;
    for (int r = 0; r < 3; r++) begin
      d_next.base_par[2-r] = base[r][0];
      d_next.frac[r]       = cfg.order ? c_s[r][8 +: avws_pkg::FRAC_BITS] : '0;
    end
    cpos = '0;
    par  = 1'b0;
    for (int k = 0; k < avws_pkg::NUM_BANKS; k++) begin
      for (int r = 0; r < 3; r++) begin
        par  = 1'(k >> (2 - r));
        cpos = base[r] + PB'(base[r][0] ^ par);
        d_next.rd_addr[k][(2-r)*BAB +: BAB] = cpos[AB-1:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_req.valid <= 1'b0;
    end else if (adv) begin
      mem_req <= d_next;
    end
  end

endmodule

// ----- rtl/avws_bank_store.sv -----
module avws_bank_store (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  avws_pkg::mem_req_t  req,
  output avws_pkg::rd_rsp_t   rsp
);

  logic [avws_pkg::VOXEL_BITS-1:0]               rd_data [avws_pkg::NUM_BANKS];
  logic                                          rd_valid;
  logic                                          rd_in_vol;
  logic [2:0]                                    rd_par;
  logic [2:0][avws_pkg::FRAC_BITS-1:0]           rd_frac;

  for (genvar k = 0; k < avws_pkg::NUM_BANKS; k++) begin : g_bank
    logic [avws_pkg::VOXEL_BITS-1:0] mem [avws_pkg::BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (adv) begin
        if (req.valid && req.is_write && req.wr_bank == 3'(k)) begin
          mem[req.wr_addr] <= req.wr_data;
        end
        rd_data[k] <= mem[req.rd_addr[k]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (adv) begin
      rd_valid <= req.valid && !req.is_write;
    end
    if (adv) begin
      rd_in_vol <= req.in_vol;
      rd_par    <= req.base_par;
      rd_frac   <= req.frac;
    end
  end

  always_comb begin
    rsp.valid    = rd_valid;
    rsp.in_vol   = rd_in_vol;
    rsp.base_par = rd_par;
    rsp.frac     = rd_frac;
    for (int k = 0; k < avws_pkg::NUM_BANKS; k++) begin
      rsp.corner[k] = rd_data[k];
    end
  end

endmodule

// ----- rtl/avws_interp.sv -----
module avws_interp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  avws_pkg::rd_rsp_t                rd,
  output logic                             o_valid,
  output logic [avws_pkg::VOXEL_BITS-1:0]  o_value,
  output logic                             o_inb
);

  localparam int VB = avws_pkg::VOXEL_BITS;
  localparam int FB = avws_pkg::FRAC_BITS;

  // Stage F: blend along x.
  logic [VB-1:0] ln_next [4];
  logic [2:0]    k0;
  logic [2:0]    k1;

  always_comb begin
    k0 = '0;
    k1 = '0;
    for (int zy = 0; zy < 4; zy++) begin
      k0 = {rd.base_par[2] ^ 1'(zy >> 1), rd.base_par[1] ^ 1'(zy), rd.base_par[0]};
      k1 = {rd.base_par[2] ^ 1'(zy >> 1), rd.base_par[1] ^ 1'(zy), ~rd.base_par[0]};
      ln_next[zy] = avws_pkg::lerp(rd.corner[k0], rd.corner[k1], rd.frac[2]);
    end
  end

  logic          f_valid;
  logic          f_inb;
  logic [VB-1:0] f_ln [4];
  logic [FB-1:0] f_fy;
  logic [FB-1:0] f_fz;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= rd.valid;
    end
    if (adv) begin
      f_inb <= rd.in_vol;
      f_fy  <= rd.frac[1];
      f_fz  <= rd.frac[0];
      for (int i = 0; i < 4; i++) begin
        f_ln[i] <= ln_next[i];
      end
    end
  end

  // Stage G: blend along y.
  logic          g_valid;
  logic          g_inb;
  logic [VB-1:0] g_pl [2];
  logic [FB-1:0] g_fz;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (adv) begin
      g_valid <= f_valid;
    end
    if (adv) begin
      g_inb   <= f_inb;
      g_fz    <= f_fz;
      g_pl[0] <= avws_pkg::lerp(f_ln[0], f_ln[1], f_fy);
      g_pl[1] <= avws_pkg::lerp(f_ln[2], f_ln[3], f_fy);
    end
  end

  // Stage H: blend along z into the output register; out of bounds samples give zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= g_valid;
    end
    if (adv) begin
      o_inb   <= g_inb;
      o_value <= g_inb ? avws_pkg::lerp(g_pl[0], g_pl[1], g_fz) : '0;
    end
  end

endmodule

// ----- rtl/affine_warp_volume_sampler_top.sv -----
// A sample request passes the transform, bank read and blend registers before its
// result is offered. Throughput: one request per cycle unless the output stalls,
// writes and samples alike; the eight parity banks of the voxel store serve all
// eight trilinear corners at once. A write updates its bank at the read stage, with no result.
// Reset (rst, synchronous, active high) empties the pipeline and restores the
// configuration defaults; the voxel store itself is not cleared.
module affine_warp_volume_sampler_top (
  input  logic       clk,
  input  logic       rst,
  avws_req_if.sink   req_ch,
  avws_rsp_if.source rsp_ch,
  avws_cfg_if.sink   cfg_ch
);

  // Configuration is taken on every cycle; the user ensures it is only written while idle.
  avws_pkg::cfg_t cfg;

  assign cfg_ch.ready = 1'b1;

  avws_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // The whole pipeline moves together. It advances whenever the output
  // register is empty or its result is being taken in this cycle, so a
  // stall freezes every stage, including the registered bank reads.
  logic                             adv;
  logic                             o_valid;
  logic [avws_pkg::VOXEL_BITS-1:0]  o_value;
  logic                             o_inb;

  assign adv          = !o_valid || rsp_ch.ready;
  assign req_ch.ready = adv;

  // Four stages: pivot offsets, coefficient products, sums, then the bounds
  // test together with base corner selection and bank addressing.
  avws_pkg::mem_req_t mem_req;

  avws_xform u_xform (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (req_ch.valid),
    .opcode      (req_ch.opcode),
    .coord_z     (req_ch.coord_z),
    .coord_y     (req_ch.coord_y),
    .coord_x     (req_ch.coord_x),
    .voxel_value (req_ch.voxel_value),
    .cfg         (cfg),
    .mem_req     (mem_req)
  );

  // The voxel store is split by the parity of each coordinate. A write goes
  // to one bank at the same stage where samples read, so requests keep
  // their order: a sample always sees every write accepted before it.
  avws_pkg::rd_rsp_t rd_rsp;

  avws_bank_store u_store (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .req (mem_req),
    .rsp (rd_rsp)
  );

  // Three blend stages along x, y and z. Nearest-neighbour lookups run
  // through them with zero weights, which pass the base corner unchanged.
  avws_interp u_interp (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .rd      (rd_rsp),
    .o_valid (o_valid),
    .o_value (o_value),
    .o_inb   (o_inb)
  );

  assign rsp_ch.valid        = o_valid;
  assign rsp_ch.warped_value = o_value;
  assign rsp_ch.in_bounds    = o_inb;

endmodule

// ----- rtl/avws_checker.sv -----
module avws_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [avws_pkg::VOXEL_BITS-1:0] rsp_value,
  input logic                            rsp_inb,
  input logic                            cfg_ready
);

  // A result that is not taken stays offered with the same payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_inb))
    else $error("result changed while stalled");

  // Out of bounds samples always carry a zero value.
  a_oob_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_inb |-> rsp_value == '0)
    else $error("out of bounds sample with nonzero value");

  // New requests are refused only while a result waits to be taken.
  a_req_ready: assert property (@(posedge clk) disable iff (rst)
    req_ready == (!rsp_valid || rsp_ready))
    else $error("request ready does not follow the output stall");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result offered right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration channel not ready");

endmodule

bind affine_warp_volume_sampler_top avws_checker u_avws_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ch.ready),
  .rsp_valid (rsp_ch.valid),
  .rsp_ready (rsp_ch.ready),
  .rsp_value (rsp_ch.warped_value),
  .rsp_inb   (rsp_ch.in_bounds),
  .cfg_ready (cfg_ch.ready)
);

// ----- tb/affine_warp_volume_sampler_top_tb.sv -----
module affine_warp_volume_sampler_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // The configuration channel has one index that no register uses.
  localparam logic [avws_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd7;
  localparam int VOLUME_DEPTH = avws_pkg::AXIS_SIZE * avws_pkg::AXIS_SIZE * avws_pkg::AXIS_SIZE;
  localparam longint ONE_VOXEL = 64'd16777216;  // 1.0 in the Q.24 source coordinate

  typedef struct {
    logic [avws_pkg::VOXEL_BITS-1:0] value;
    logic                            inb;
  } sample_t;

  logic clk;
  logic rst;

  avws_req_if req_ch ();
  avws_rsp_if rsp_ch ();
  avws_cfg_if cfg_ch ();

  affine_warp_volume_sampler_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .rsp_ch (rsp_ch),
    .cfg_ch (cfg_ch)
  );

  // Our own copy of the warp settings and of the voxel store. The written
  // map lets the stimulus make sure no sample ever touches an entry that
  // was never stored, since the store is undefined after reset.
  logic [avws_pkg::CFG_DATA_BITS-1:0] warp_rows [3];
  logic [avws_pkg::CFG_DATA_BITS-1:0] warp_trans;
  logic [avws_pkg::CFG_DATA_BITS-1:0] warp_pivot;
  logic [avws_pkg::DIMS_BITS-1:0]     warp_dims;
  logic                               warp_order;
  logic [avws_pkg::VOXEL_BITS-1:0]    volume [VOLUME_DEPTH];
  bit                                 written [VOLUME_DEPTH];

  sample_t pending_samples[$];
  int      errors;
  int      sent;

  // Idle percentages for the request sender and the result receiver, and a
  // counter that forces the receiver to hold off for a long stretch.
  int src_idle;
  int snk_idle;
  int hold_left;

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // The receiver changes its ready at the falling edge. While a hold-off is
  // running it stays low no matter what the idle setting says.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // Every accepted result is checked against the oldest expected sample.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected result value=%h in_bounds=%b", $time,
                 rsp_ch.warped_value, rsp_ch.in_bounds);
        errors++;
      end else begin
        sample_t exp_s;
        exp_s = pending_samples.pop_front();
        if (rsp_ch.warped_value !== exp_s.value) begin
          $display("%0t: warped_value expected %h actual %h", $time, exp_s.value,
                   rsp_ch.warped_value);
          errors++;
        end
        if (rsp_ch.in_bounds !== exp_s.inb) begin
          $display("%0t: in_bounds expected %b actual %b", $time, exp_s.inb,
                   rsp_ch.in_bounds);
          errors++;
        end
      end
    end
  end

  function automatic longint sfield(input logic [avws_pkg::CFG_DATA_BITS-1:0] packed_val,
                                    input int slot);
    logic signed [avws_pkg::FIELD_BITS-1:0] f;
    f = packed_val[slot*avws_pkg::FIELD_BITS +: avws_pkg::FIELD_BITS];
    return longint'(f);
  endfunction

  function automatic logic [avws_pkg::CFG_DATA_BITS-1:0] pack3(input int z, input int y,
                                                               input int x);
    logic [avws_pkg::FIELD_BITS-1:0] fz, fy, fx;
    fz = z[avws_pkg::FIELD_BITS-1:0];
    fy = y[avws_pkg::FIELD_BITS-1:0];
    fx = x[avws_pkg::FIELD_BITS-1:0];
    return {fx, fy, fz};
  endfunction

  function automatic int voxel_index(input longint z, input longint y, input longint x);
    return int'((z * avws_pkg::AXIS_SIZE + y) * avws_pkg::AXIS_SIZE + x);
  endfunction

  // Maps an output coordinate into the source volume (exact Q.24) and applies
  // the bounds test with the interpolation order as margin.
  function automatic void warp_point(input bit [avws_pkg::AXIS_BITS-1:0] z, y, x,
                                     output longint src [3], output longint dim [3],
                                     output bit in_vol);
    longint offs [3];
    longint acc;
    longint margin;
    offs[0] = longint'(z) * 256 - sfield(warp_pivot, 0);
    offs[1] = longint'(y) * 256 - sfield(warp_pivot, 1);
    offs[2] = longint'(x) * 256 - sfield(warp_pivot, 2);
    margin = warp_order ? 1 : 0;
    in_vol = 1'b1;
    for (int r = 0; r < 3; r++) begin
      acc = (sfield(warp_trans, r) + sfield(warp_pivot, r)) * 65536;
      for (int c = 0; c < 3; c++) acc += sfield(warp_rows[r], c) * offs[c];
      src[r] = acc;
      dim[r] = longint'(warp_dims[r*avws_pkg::DIM_BITS +: avws_pkg::DIM_BITS]);
      if (dim[r] > avws_pkg::AXIS_SIZE) dim[r] = avws_pkg::AXIS_SIZE;
      if (acc < margin * ONE_VOXEL || acc >= (dim[r] - margin) * ONE_VOXEL) in_vol = 1'b0;
    end
  endfunction

  // Nearest neighbour rounds half up and clamps to the last voxel of the axis.
  function automatic longint nearest_index(input longint src, input longint dim);
    longint q;
    q = (src + ONE_VOXEL / 2) >>> 24;
    return (q > dim - 1) ? dim - 1 : q;
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint f);
    return (a * (65536 - f) + b * f + 32768) >>> 16;
  endfunction

  function automatic sample_t predict_sample(input bit [avws_pkg::AXIS_BITS-1:0] z, y, x);
    longint src [3], dim [3], base [3], frac [3];
    longint lines [2], planes [2], val;
    bit in_vol;
    sample_t res;
    warp_point(z, y, x, src, dim, in_vol);
    if (!in_vol) begin
      res.value = '0;
      res.inb = 1'b0;
      return res;
    end
    if (!warp_order) begin
      val = volume[voxel_index(nearest_index(src[0], dim[0]), nearest_index(src[1], dim[1]),
                               nearest_index(src[2], dim[2]))];
    end else begin
      for (int r = 0; r < 3; r++) begin
        base[r] = src[r] >>> 24;
        frac[r] = (src[r] & 64'hFF_FFFF) >>> 8;
      end
      // Blend along x first, then y, then z.
      for (int dz = 0; dz < 2; dz++) begin
        for (int dy = 0; dy < 2; dy++) begin
          lines[dy] = blend(volume[voxel_index(base[0] + dz, base[1] + dy, base[2])],
                            volume[voxel_index(base[0] + dz, base[1] + dy, base[2] + 1)],
                            frac[2]);
        end
        planes[dz] = blend(lines[0], lines[1], frac[1]);
      end
      val = blend(planes[0], planes[1], frac[0]);
    end
    res.value = (val > 65535) ? 16'hFFFF : val[avws_pkg::VOXEL_BITS-1:0];
    res.inb = 1'b1;
    return res;
  endfunction

  // Offers one request and waits until it is taken. The expectation is
  // formed at the moment of acceptance so it sees the store as the block does.
  task automatic send_request(input logic op, input bit [avws_pkg::AXIS_BITS-1:0] z, y, x,
                              input logic [avws_pkg::VOXEL_BITS-1:0] val);
    while ($urandom_range(99) < src_idle) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.coord_z <= z;
    req_ch.coord_y <= y;
    req_ch.coord_x <= x;
    req_ch.voxel_value <= val;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
    if (op == avws_pkg::OP_WRITE) begin
      volume[voxel_index(z, y, x)] = val;
      written[voxel_index(z, y, x)] = 1'b1;
    end else begin
      pending_samples.push_back(predict_sample(z, y, x));
    end
    @(negedge clk);
  endtask

  task automatic store_if_missing(input longint z, input longint y, input longint x);
    if (!written[voxel_index(z, y, x)])
      send_request(avws_pkg::OP_WRITE, z[avws_pkg::AXIS_BITS-1:0], y[avws_pkg::AXIS_BITS-1:0],
                   x[avws_pkg::AXIS_BITS-1:0], avws_pkg::VOXEL_BITS'($urandom));
  endtask

  // Stores every voxel the sample would read that was never written, then
  // sends the sample itself.
  task automatic send_sample(input bit [avws_pkg::AXIS_BITS-1:0] z, y, x);
    longint src [3], dim [3];
    bit in_vol;
    warp_point(z, y, x, src, dim, in_vol);
    if (in_vol) begin
      if (!warp_order) begin
        store_if_missing(nearest_index(src[0], dim[0]), nearest_index(src[1], dim[1]),
                         nearest_index(src[2], dim[2]));
      end else begin
        for (int c = 0; c < 8; c++)
          store_if_missing((src[0] >>> 24) + c[2], (src[1] >>> 24) + c[1],
                           (src[2] >>> 24) + c[0]);
      end
    end
    send_request(avws_pkg::OP_SAMPLE, z, y, x, avws_pkg::VOXEL_BITS'($urandom));
  endtask

  task automatic write_register(input logic [avws_pkg::CFG_IDX_BITS-1:0] idx,
                                input logic [avws_pkg::CFG_DATA_BITS-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      avws_pkg::CFG_ROW_Z: warp_rows[0] = val;
      avws_pkg::CFG_ROW_Y: warp_rows[1] = val;
      avws_pkg::CFG_ROW_X: warp_rows[2] = val;
      avws_pkg::CFG_TRANS: warp_trans = val;
      avws_pkg::CFG_PIVOT: warp_pivot = val;
      avws_pkg::CFG_DIMS:  warp_dims = val[avws_pkg::DIMS_BITS-1:0];
      avws_pkg::CFG_ORDER: warp_order = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Waits until every sample has come back, plus the write latency, so that
  // no request is in flight when the settings change.
  task automatic drain;
    req_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_warp(input logic [avws_pkg::CFG_DATA_BITS-1:0] rz, ry, rx, tr, pv,
                          input logic [avws_pkg::DIMS_BITS-1:0] dims, input logic order);
    drain();
    write_register(avws_pkg::CFG_ROW_Z, rz);
    write_register(avws_pkg::CFG_ROW_Y, ry);
    write_register(avws_pkg::CFG_ROW_X, rx);
    write_register(avws_pkg::CFG_TRANS, tr);
    write_register(avws_pkg::CFG_PIVOT, pv);
    write_register(avws_pkg::CFG_DIMS, avws_pkg::CFG_DATA_BITS'(dims));
    write_register(avws_pkg::CFG_ORDER, avws_pkg::CFG_DATA_BITS'(order));
  endtask

  function automatic logic [avws_pkg::DIMS_BITS-1:0] pack_dims(input int d, input int h,
                                                               input int w);
    return {w[avws_pkg::DIM_BITS-1:0], h[avws_pkg::DIM_BITS-1:0], d[avws_pkg::DIM_BITS-1:0]};
  endfunction

  // Edges of the volume in both orders, plus the unused register index.
  task automatic test_directed;
    bit [avws_pkg::AXIS_BITS-1:0] pts [5] = '{6'd0, 6'd1, 6'd31, 6'd62, 6'd63};
    src_idle = 0;
    snk_idle = 0;
    write_register(CFG_UNUSED, '1);
    foreach (pts[i]) send_sample(pts[i], pts[4 - i], pts[i]);
    send_request(avws_pkg::OP_WRITE, 6'd63, 6'd63, 6'd63, 16'hFFFF);
    send_request(avws_pkg::OP_WRITE, 6'd0, 6'd0, 6'd0, 16'h0000);
    send_sample(6'd62, 6'd62, 6'd62);
    // Nearest neighbour, with a half voxel shift to hit the round-half-up case
    // and the clamp at the far edge.
    set_warp(avws_pkg::ROW_Z_RESET, avws_pkg::ROW_Y_RESET, avws_pkg::ROW_X_RESET,
             pack3(128, 128, 154), '0, avws_pkg::DIMS_RESET, 1'b0);
    foreach (pts[i]) send_sample(pts[i], pts[i], pts[i]);
    send_sample(6'd0, 6'd63, 6'd62);
  endtask

  // A run of random traffic under the current settings: mostly samples that
  // land near the source volume, some plain writes anywhere. The count covers
  // every request sent, the stores that a sample needs first included.
  task automatic random_traffic(input int count);
    int reach;
    int stop;
    reach = 0;
    stop = sent + count;
    for (int r = 0; r < 3; r++)
      reach = (warp_dims[r*avws_pkg::DIM_BITS +: avws_pkg::DIM_BITS] > reach)
            ? warp_dims[r*avws_pkg::DIM_BITS +: avws_pkg::DIM_BITS] : reach;
    reach = (reach > 62) ? 63 : reach + 1;
    while (sent < stop) begin
      if ($urandom_range(99) < 30)
        send_request(avws_pkg::OP_WRITE, avws_pkg::AXIS_BITS'($urandom),
                     avws_pkg::AXIS_BITS'($urandom), avws_pkg::AXIS_BITS'($urandom),
                     avws_pkg::VOXEL_BITS'($urandom));
      else if ($urandom_range(1))
        send_sample(avws_pkg::AXIS_BITS'($urandom), avws_pkg::AXIS_BITS'($urandom),
                    avws_pkg::AXIS_BITS'($urandom));
      else
        send_sample(avws_pkg::AXIS_BITS'($urandom_range(reach)),
                    avws_pkg::AXIS_BITS'($urandom_range(reach)),
                    avws_pkg::AXIS_BITS'($urandom_range(reach)));
    end
  endtask

  function automatic int near(input int centre, input int spread);
    return centre + $urandom_range(2 * spread) - spread;
  endfunction

  // Walks through a range of warp settings, extremes among them, with the
  // three idling patterns spread over the phases.
  task automatic test_config_sweep;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_warp(avws_pkg::ROW_Z_RESET, avws_pkg::ROW_Y_RESET, avws_pkg::ROW_X_RESET,
                    '0, '0, avws_pkg::DIMS_RESET, 1'b1);
        1: set_warp(pack3(near(65536, 12000), near(0, 8000), near(0, 8000)),
                    pack3(near(0, 8000), near(65536, 12000), near(0, 8000)),
                    pack3(near(0, 8000), near(0, 8000), near(65536, 12000)),
                    pack3(near(0, 900), near(0, 900), near(0, 900)),
                    pack3(8192, 8192, 8192), avws_pkg::DIMS_RESET, 1'b1);
        2: set_warp(pack3(32768, 0, 0), pack3(0, 32768, 0), pack3(0, 0, 32768),
                    pack3(near(0, 300), near(0, 300), near(0, 300)),
                    pack3(near(0, 4000), near(0, 4000), near(0, 4000)),
                    pack_dims(20, 33, 17), 1'b1);
        // Most negative and most positive fields everywhere; dims above the
        // store size saturate.
        3: set_warp(pack3(-524288, 524287, -524288), pack3(524287, -524288, 524287),
                    pack3(-524288, -524288, 524287), pack3(524287, -524288, 524287),
                    pack3(-524288, 524287, -524288), '1, 1'b0);
        // A zero dim and dims too small for the trilinear margin.
        4: set_warp(avws_pkg::ROW_Z_RESET, avws_pkg::ROW_Y_RESET, avws_pkg::ROW_X_RESET,
                    '0, '0, pack_dims(2, 2, 0), 1'b1);
        5: set_warp(avws_pkg::ROW_Z_RESET, avws_pkg::ROW_Y_RESET, avws_pkg::ROW_X_RESET,
                    '0, '0, pack_dims(2, 2, 2), 1'b1);
        6: set_warp(avws_pkg::ROW_Z_RESET, avws_pkg::ROW_Y_RESET, avws_pkg::ROW_X_RESET,
                    '0, '0, pack_dims(1, 1, 1), 1'b0);
        // Axis swap with a shift, and a shift of just over half a voxel so
        // the nearest index rounds past the far edge.
        default: set_warp(pack3(0, 0, 65536), pack3(0, 65536, 0), pack3(65536, 0, 0),
                          pack3(154, near(0, 200), 154), pack3(near(0, 2000), 0, 0),
                          pack_dims(40, 64, 9), 1'b0);
      endcase
      src_idle = (ph < 3) ? 30 : (ph < 6) ? 69 : 0;
      snk_idle = (ph < 3) ? 69 : (ph < 6) ? 30 : 0;
      random_traffic(85);
    end
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the
  // pipeline fills and the block must stall its input.
  task automatic test_backpressure;
    set_warp(avws_pkg::ROW_Z_RESET, avws_pkg::ROW_Y_RESET, avws_pkg::ROW_X_RESET,
             pack3(64, 64, 64), '0, avws_pkg::DIMS_RESET, 1'b1);
    src_idle = 0;
    snk_idle = 0;
    @(posedge clk);
    hold_left = 300;
    @(negedge clk);
    random_traffic(60);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    errors = 0;
    sent = 0;
    src_idle = 0;
    snk_idle = 0;
    hold_left = 0;
    req_ch.valid = 1'b0;
    req_ch.opcode = avws_pkg::OP_WRITE;
    req_ch.coord_z = '0;
    req_ch.coord_y = '0;
    req_ch.coord_x = '0;
    req_ch.voxel_value = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = avws_pkg::CFG_ROW_Z;
    cfg_ch.data = '0;
    warp_rows[0] = avws_pkg::ROW_Z_RESET;
    warp_rows[1] = avws_pkg::ROW_Y_RESET;
    warp_rows[2] = avws_pkg::ROW_X_RESET;
    warp_trans = '0;
    warp_pivot = '0;
    warp_dims = avws_pkg::DIMS_RESET;
    warp_order = 1'b1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_config_sweep();
    test_backpressure();

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/avws_pkg.sv
rtl/avws_if.sv
rtl/avws_cfg_regs.sv
rtl/avws_xform.sv
rtl/avws_bank_store.sv
rtl/avws_interp.sv
rtl/affine_warp_volume_sampler_top.sv
rtl/avws_checker.sv
tb/affine_warp_volume_sampler_top_tb.sv
